[rtl/dq_pkg.sv]
`default_nettype none
package dq_pkg;

  localparam int DEPTH = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KIND_W = 3;
  localparam int STATUS_W = 2;
  localparam int PORT_W = 32;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_REVERSE    = 3'd4,
    KIND_CLEAR      = 3'd5,
    KIND_PEEK       = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_SHIFT_UP,
    CH_SHIFT_DOWN,
    CH_WRITE_TAIL
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    word_t     value;
  } chain_ctrl_t;

endpackage
`default_nettype wire

[rtl/dq_cell.sv]
`default_nettype none
module dq_cell (
  input  wire logic               clk,
  input  wire dq_pkg::chain_ctrl_t ctrl,
  input  wire logic               hit,
  input  wire dq_pkg::word_t      left,
  input  wire dq_pkg::word_t      right,
  output dq_pkg::word_t           data
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      dq_pkg::CH_SHIFT_UP: begin
        data <= left;
      end
      dq_pkg::CH_SHIFT_DOWN: begin
        data <= right;
      end
      dq_pkg::CH_WRITE_TAIL: begin
        if (hit) begin
          data <= ctrl.value;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/dq_chain.sv]
`default_nettype none
module dq_chain (
  input  wire logic                clk,
  input  wire dq_pkg::chain_ctrl_t ctrl,
  input  wire dq_pkg::cnt_t        tail,
  output dq_pkg::word_t            head
);

  dq_pkg::word_t cell_data [dq_pkg::DEPTH];

  for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
    dq_pkg::word_t left;
    dq_pkg::word_t right;
    logic          hit;

    if (i == 0) begin : g_first
      assign left = ctrl.value;
    end else begin : g_inner_left
      assign left = cell_data[i-1];
    end

    if (i == dq_pkg::DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner_right
      assign right = cell_data[i+1];
    end

    assign hit = (tail == dq_pkg::CNT_W'(i));

    dq_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .hit   (hit),
      .left  (left),
      .right (right),
      .data  (cell_data[i])
    );
  end

  assign head = cell_data[0];

endmodule
`default_nettype wire

[rtl/double_ended_queue_core.sv]
`default_nettype none
// Bounded double-ended queue of signed words with 64 entries.
// A transaction is taken at a rising edge where start is high and busy is low.
// The kind port selects push front, push back, pop front, pop back, reverse,
// clear or peek, and value carries the word for the push operations.
// Every transaction gives exactly one result, shown for one cycle with done
// high in the cycle right after the transaction is taken.
// The result carries the front and back values, the count, an empty flag and
// a status that flags a push into a full queue or a pop from an empty one.
// A new transaction may be taken in every cycle, so busy stays low. A push
// is one shift in one row and one tail write in the other, and a pop one
// shift; there are two rows of cells, one holding the words from the front
// and one from the back. Reverse only flips which row is the front.
// Reset empties the queue, clears the reverse flag and drops done.
// The receiver cannot stall, so every result must be taken when shown.
module double_ended_queue_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [dq_pkg::KIND_W-1:0]        kind,
  input  wire logic signed [dq_pkg::PORT_W-1:0] value,
  output logic                                  done,
  output logic signed [dq_pkg::PORT_W-1:0]      front_value,
  output logic signed [dq_pkg::PORT_W-1:0]      back_value,
  output logic [dq_pkg::CNT_W-1:0]              count,
  output logic                                  is_empty,
  output logic [dq_pkg::STATUS_W-1:0]           status
);

  dq_pkg::cnt_t        held;
  dq_pkg::cnt_t        held_next;
  logic                reversed;
  logic                reversed_next;
  dq_pkg::status_t     status_next;
  dq_pkg::status_t     status_q;
  dq_pkg::chain_ctrl_t fwd_ctrl;
  dq_pkg::chain_ctrl_t bwd_ctrl;
  dq_pkg::word_t       fwd_head;
  dq_pkg::word_t       bwd_head;
  dq_pkg::word_t       word_in;
  logic                accept;
  logic                at_start;
  logic                full;
  logic                empty;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign word_in  = dq_pkg::DATA_WIDTH'($unsigned(value));
  assign full     = (held == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign empty    = (held == '0);
  assign at_start = ((kind == dq_pkg::KIND_PUSH_FRONT) || (kind == dq_pkg::KIND_POP_FRONT))
                    != reversed;

  always_comb begin
    held_next      = held;
    reversed_next  = reversed;
    status_next    = dq_pkg::ST_OK;
    fwd_ctrl.op    = dq_pkg::CH_HOLD;
    fwd_ctrl.value = word_in;
    bwd_ctrl.op    = dq_pkg::CH_HOLD;
    bwd_ctrl.value = word_in;
    case (kind)
      dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          status_next = dq_pkg::ST_FULL;
        end else begin
          held_next = held + 1'b1;
          if (at_start) begin
            fwd_ctrl.op = dq_pkg::CH_SHIFT_UP;
            bwd_ctrl.op = dq_pkg::CH_WRITE_TAIL;
          end else begin
            fwd_ctrl.op = dq_pkg::CH_WRITE_TAIL;
            bwd_ctrl.op = dq_pkg::CH_SHIFT_UP;
          end
        end
      end
      dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_BACK: begin
        if (empty) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          held_next = held - 1'b1;
          if (at_start) begin
            fwd_ctrl.op = dq_pkg::CH_SHIFT_DOWN;
          end else begin
            bwd_ctrl.op = dq_pkg::CH_SHIFT_DOWN;
          end
        end
      end
      dq_pkg::KIND_REVERSE: begin
        reversed_next = !reversed;
      end
      dq_pkg::KIND_CLEAR: begin
        held_next     = '0;
        reversed_next = 1'b0;
      end
      default: begin
        held_next = held;
      end
    endcase
    if (!accept) begin
      fwd_ctrl.op = dq_pkg::CH_HOLD;
      bwd_ctrl.op = dq_pkg::CH_HOLD;
    end
  end

  dq_chain u_fwd (
    .clk  (clk),
    .ctrl (fwd_ctrl),
    .tail (held),
    .head (fwd_head)
  );

  dq_chain u_bwd (
    .clk  (clk),
    .ctrl (bwd_ctrl),
    .tail (held),
    .head (bwd_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      reversed <= 1'b0;
      done     <= 1'b0;
      status_q <= dq_pkg::ST_OK;
    end else begin
      done <= accept;
      if (accept) begin
        held     <= held_next;
        reversed <= reversed_next;
        status_q <= status_next;
      end
    end
  end

  assign count       = held;
  assign is_empty    = empty;
  assign status      = status_q;
  assign front_value = empty ? '0 : dq_pkg::PORT_W'(reversed ? bwd_head : fwd_head);
  assign back_value  = empty ? '0 : dq_pkg::PORT_W'(reversed ? fwd_head : bwd_head);

endmodule
`default_nettype wire

[rtl/dq_checker.sv]
`default_nettype none
module dq_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             done,
  input wire logic signed [dq_pkg::PORT_W-1:0] front_value,
  input wire logic signed [dq_pkg::PORT_W-1:0] back_value,
  input wire logic [dq_pkg::CNT_W-1:0]         count,
  input wire logic                             is_empty,
  input wire logic [dq_pkg::STATUS_W-1:0]      status
);

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("A taken transaction gave no result in the next cycle.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("A result appeared without a transaction.");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (front_value == '0 && back_value == '0 && count == '0))
    else $error("An empty queue showed nonzero values or count.");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (done && status == dq_pkg::ST_FULL) |-> (count == dq_pkg::CNT_W'(dq_pkg::DEPTH)))
    else $error("A push was rejected while the queue was not full.");

  a_empty_reject: assert property (@(posedge clk) disable iff (rst)
    (done && status == dq_pkg::ST_EMPTY) |-> is_empty)
    else $error("A pop was rejected while the queue held elements.");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .front_value (front_value),
  .back_value  (back_value),
  .count       (count),
  .is_empty    (is_empty),
  .status      (status)
);
`default_nettype wire
